// File: rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/tlc_pkg.sv
`timescale 1ns / 1ps

package tlc_pkg;

    localparam int LINE_BUF_DEF = 64;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7F;

    // controller to datapath
    typedef struct packed {
        logic load;        // input item accepted
        logic start;       // new emission, reset scan and trim length
        logic scan;        // step generator, find trimmed length
        logic rewind;      // restart generator for the output pass
        logic emit;        // step generator, load output register
        logic emit_empty;  // load the empty-line item
        logic clear;       // line finished, clear line state
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic trigger;     // accepted item would end a line
        logic gen_done;    // generator has walked the whole store
        logic emit_done;   // all trimmed characters sent
        logic nlast_zero;  // trimmed line is empty
        logic out_free;    // output register can take an item
    } status_t;

endpackage

// File: rtl/tlc_ctrl.sv
`timescale 1ns / 1ps

module tlc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  tlc_pkg::status_t status,
    output tlc_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (status.trigger)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.gen_done)
                begin
                    cmd.rewind = 1'b1;
                    state_next = status.nlast_zero ? ST_EMPTY : ST_EMIT;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (status.emit_done)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    cmd.clear      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/tlc_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlc_datapath #(
    parameter int LINE_BUF = tlc_pkg::LINE_BUF_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tlc_pkg::cmd_t    cmd,
    output tlc_pkg::status_t status,
    input  logic [7:0]       in_byte,
    input  logic             in_eoi,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_char,
    output logic             out_empty,
    output logic             out_last
);

    localparam int CW = $clog2(LINE_BUF);
    localparam logic [CW-1:0] LIMIT = CW'(LINE_BUF - 1);

    logic [7:0]    mem [LINE_BUF];
    logic [7:0]    q_reg;

    logic [CW-1:0] fill_reg;
    logic          discarding_reg;
    logic          line_open_reg;

    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [2:0]    col_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] nlast_reg;

    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          out_empty_reg;
    logic          out_last_reg;

    logic          is_nl;
    logic          is_drop;
    logic          is_tab;
    logic [7:0]    gen_ch;
    logic [2:0]    col_inc;
    logic          adv;
    logic          step;
    logic          n_room;
    logic [CW-1:0] n_plus;
    logic [CW-1:0] fill_plus;

    assign is_nl   = (in_byte == tlc_pkg::CH_NL);
    assign is_drop = ((in_byte < tlc_pkg::CH_SP) && (in_byte != tlc_pkg::CH_TAB))
                     || (in_byte == tlc_pkg::CH_DEL);

    // canonical character generator: one expanded column per step
    assign is_tab  = (q_reg == tlc_pkg::CH_TAB);
    assign gen_ch  = is_tab ? tlc_pkg::CH_SP : q_reg;
    assign col_inc = col_reg + 3'd1;
    assign adv     = !is_tab || (col_inc == 3'd0);
    assign step    = cmd.scan || cmd.emit;
    assign n_room  = (n_reg < LIMIT);
    assign n_plus  = n_reg + CW'(1);
    assign fill_plus = fill_reg + CW'(1);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.start || cmd.rewind)
        begin
            idx_next = '0;
        end
        else if (step && adv)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_comb
    begin
        status.trigger    = in_eoi ? line_open_reg : is_nl;
        status.gen_done   = (idx_reg == fill_reg);
        status.emit_done  = (n_reg == nlast_reg);
        status.nlast_zero = (nlast_reg == '0);
        status.out_free   = !out_valid_reg || out_ready;
    end

    // line store, registered read at the generator's next index
    always_ff @(posedge clk)
    begin
        if (cmd.load && !in_eoi && !is_nl && !discarding_reg
            && (in_byte != tlc_pkg::CH_BS) && !is_drop)
        begin
            mem[fill_reg] <= in_byte;
        end
        q_reg <= mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            discarding_reg <= 1'b0;
            line_open_reg  <= 1'b0;
        end
        else if (cmd.clear || (cmd.load && in_eoi && !line_open_reg))
        begin
            fill_reg       <= '0;
            discarding_reg <= 1'b0;
            line_open_reg  <= 1'b0;
        end
        else if (cmd.load && !in_eoi && !is_nl)
        begin
            line_open_reg <= 1'b1;
            if (!discarding_reg)
            begin
                if (in_byte == tlc_pkg::CH_BS)
                begin
                    if (fill_reg != '0)
                    begin
                        fill_reg <= fill_reg - CW'(1);
                    end
                end
                else if (!is_drop)
                begin
                    fill_reg <= fill_plus;
                    if (fill_plus == LIMIT)
                    begin
                        discarding_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            col_reg   <= '0;
            n_reg     <= '0;
            nlast_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.start || cmd.rewind)
            begin
                col_reg <= '0;
                n_reg   <= '0;
                if (cmd.start)
                begin
                    nlast_reg <= '0;
                end
            end
            else if (step)
            begin
                col_reg <= col_inc;
                if (n_room)
                begin
                    n_reg <= n_plus;
                end
                // trimmed length follows the last visible character
                if (cmd.scan && n_room && (gen_ch != tlc_pkg::CH_SP))
                begin
                    nlast_reg <= n_plus;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.emit_empty)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg  <= gen_ch;
            out_empty_reg <= 1'b0;
            out_last_reg  <= (n_plus == nlast_reg);
        end
        else if (cmd.emit_empty)
        begin
            out_char_reg  <= 8'h00;
            out_empty_reg <= 1'b1;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_empty = out_empty_reg;
    assign out_last  = out_last_reg;

    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= LIMIT, "fill count beyond store limit")
    `ASSERT_IMPLY(a_emit_in_range, clk, rst_n, cmd.emit, n_reg < nlast_reg, "emit beyond trimmed length")
    `ASSERT_IMPLY(a_empty_item, clk, rst_n, out_valid_reg && out_empty_reg, out_last_reg && (out_char_reg == 8'h00), "empty item malformed")

endmodule

// File: rtl/text_line_canonicalizer.sv
`timescale 1ns / 1ps
// text line canonicaliser: raw text bytes in, canonical lines out
// slave channel takes one item per byte: tdata = character, tuser = end of input
// while a line is being built a byte is taken every cycle; backspace, dropped
// control codes and bytes past the store limit are taken at that rate as well
// a newline (or end of input with a line open) closes tready while the line is
// worked out: a scan pass over the expanded columns of the stored line finds
// the length after trailing blanks are stripped, then an output pass drains the
// line item by item through the master channel; the store is read once per cycle
// master channel: tdata = character, tuser = empty line flag, tlast = last of line
// an empty line goes out as one item with char 0, tuser and tlast high
// a stall on the master side holds the output register and pauses the output
// pass; input is taken again when the sequencer returns to idle through a closing
// step after the last item is loaded there, or straight after it for an empty line
// reset clears the fill count and flags and empties the output register; the
// store itself holds no reset and its contents are only used below the fill count

module text_line_canonicalizer #(
    parameter int LINE_BUF = tlc_pkg::LINE_BUF_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_in
    input  logic [0:0] s_tuser,   // [0] end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic [0:0] m_tuser,   // [0] empty_line
    output logic       m_tlast    // last_of_line
);

    tlc_pkg::cmd_t    cmd;
    tlc_pkg::status_t status;

    // sequencer: accept, scan, output pass
    tlc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // line store, tab expansion generator and output register
    tlc_datapath #(
        .LINE_BUF (LINE_BUF)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (s_tdata),
        .in_eoi    (s_tuser[0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_empty (m_tuser[0]),
        .out_last  (m_tlast)
    );

endmodule

// File: sim/tb_text_line_canonicalizer.sv
`timescale 1ns / 1ps

module tb_text_line_canonicalizer;

    localparam int LINE_BUF = tlc_pkg::LINE_BUF_DEF;
    localparam int DIRECTED_N = 25;
    localparam int RANDOM_ITEMS = 125;
    // longest scan pass is eight columns per stored tab, plus the output pass
    localparam int DRAIN_CYCLES = 600;
    // receiver long hold-off, long enough for the block to stall its input
    localparam int LONG_HOLD = 600;
    localparam int HOLD_AT_CHAR = 25;
    // bit 8 of a directed entry marks an end-of-input item
    localparam logic [8:0] END_MARK = 9'h100;

    typedef enum {MIXED, TAB_HEAVY, PRINTABLE} text_mix_t;

    // predicts the canonical lines and holds the characters still to come
    class canon_line_checker;
        typedef struct packed {
            logic [7:0] ch;
            logic       empty;
            logic       last;
        } canon_char_t;

        logic [7:0]  line_buf [64];
        int unsigned fill;
        bit          discarding;
        bit          line_open;
        canon_char_t canon_q [$];
        int          errors;

        function new();
            fill = 0;
            discarding = 0;
            line_open = 0;
            errors = 0;
        endfunction

        function void clear_line();
            fill = 0;
            discarding = 0;
            line_open = 0;
        endfunction

        // expand tabs, cut to LINE_BUF-1, strip trailing blanks, queue the result
        function void build_canon_line();
            logic [7:0]  canon [$];
            canon_char_t c;
            int unsigned col;
            int unsigned i;
            col = 0;
            for (i = 0; i < fill; i++) begin
                if (line_buf[i] != tlc_pkg::CH_TAB) begin
                    col++;
                    if (canon.size() < LINE_BUF - 1)
                        canon.push_back(line_buf[i]);
                end
                else begin
                    // columns keep counting past the cut so later stops stay right
                    do
                    begin
                        if (canon.size() < LINE_BUF - 1)
                            canon.push_back(tlc_pkg::CH_SP);
                        col++;
                    end
                    while (col % 8 != 0);
                end
            end
            while (canon.size() > 0 && canon[canon.size() - 1] == tlc_pkg::CH_SP)
                void'(canon.pop_back());
            if (canon.size() == 0) begin
                c.ch = 8'h00;
                c.empty = 1'b1;
                c.last = 1'b1;
                canon_q.push_back(c);
            end
            else begin
                for (i = 0; i < canon.size(); i++) begin
                    c.ch = canon[i];
                    c.empty = 1'b0;
                    c.last = (i == canon.size() - 1);
                    canon_q.push_back(c);
                end
            end
        endfunction

        function void take_byte(logic [7:0] b, logic eoi);
            if (eoi) begin
                if (line_open)
                    build_canon_line();
                clear_line();
                return;
            end
            if (b == tlc_pkg::CH_NL) begin
                build_canon_line();
                clear_line();
                return;
            end
            line_open = 1;
            if (discarding)
                return;
            if (b == tlc_pkg::CH_BS) begin
                if (fill > 0)
                    fill--;
                return;
            end
            if ((b < tlc_pkg::CH_SP && b != tlc_pkg::CH_TAB) || b == tlc_pkg::CH_DEL)
                return;
            line_buf[fill] = b;
            fill++;
            if (fill >= LINE_BUF - 1)
                discarding = 1;
        endfunction

        function void check_char(logic [7:0] ch, logic empty, logic last);
            canon_char_t want;
            if (canon_q.size() == 0) begin
                $error("char_out %h arrived with no character expected", ch);
                errors++;
                return;
            end
            want = canon_q.pop_front();
            if (ch !== want.ch) begin
                $error("char_out: expected %h, got %h", want.ch, ch);
                errors++;
            end
            if (empty !== want.empty) begin
                $error("empty_line: expected %b, got %b", want.empty, empty);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_line: expected %b, got %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic [0:0] s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;

    canon_line_checker chk = new();

    int          items_sent = 0;
    int          burst_left = 0;
    int unsigned rx_cycle = 0;
    int          rx_taken = 0;
    int          hold_left = 0;

    text_line_canonicalizer #(
        .LINE_BUF (LINE_BUF)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] byte_in
        .s_tuser  (s_tuser),    // [0] end_of_input
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] char_out
        .m_tuser  (m_tuser),    // [0] empty_line
        .m_tlast  (m_tlast)     // last_of_line
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // both handshakes are sampled at the edge, before any update of this step
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                chk.take_byte(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready)
                chk.check_char(m_tdata, m_tuser[0], m_tlast);
        end
    end

    // receiver: cycles through always ready, coin toss, rare stalls and a fixed
    // pattern; once, after HOLD_AT_CHAR characters, it holds off for a long stretch
    always @(posedge clk)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            rx_cycle++;
            if (m_tvalid && m_tready) begin
                rx_taken++;
                if (rx_taken == HOLD_AT_CHAR)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else begin
                case ((rx_cycle >> 8) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ((rx_cycle % 5) >= 2);
                endcase
            end
        end
    end

    // sender pacing: random bursts, now and then a long one, with random gaps
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // offer one item and wait for it to be taken
    task automatic send_item(input logic [7:0] b, input logic eoi);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= eoi;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        pace();
    endtask

    function automatic logic [7:0] pick_byte(text_mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            TAB_HEAVY:
                return (r < 50) ? tlc_pkg::CH_TAB
                     : (r < 65) ? tlc_pkg::CH_SP
                     : 8'($urandom_range(8'h21, 8'h7e));
            PRINTABLE:
                return (r < 15) ? tlc_pkg::CH_SP : 8'($urandom_range(8'h21, 8'h7e));
            default:
            begin
                if (r < 55)
                    return 8'($urandom_range(8'h21, 8'h7e));
                else if (r < 65)
                    return tlc_pkg::CH_SP;
                else if (r < 73)
                    return tlc_pkg::CH_TAB;
                else if (r < 80)
                    return tlc_pkg::CH_BS;
                else if (r < 87)
                    return 8'($urandom_range(8'h00, 8'h1f));
                else if (r < 92)
                    return tlc_pkg::CH_DEL;
                else
                    return 8'($urandom_range(8'h80, 8'hff));
            end
        endcase
    endfunction

    // line body only, the caller picks how it ends
    task automatic send_line(input int len, input text_mix_t mix);
        int i;
        for (i = 0; i < len; i++)
            send_item(pick_byte(mix), 1'b0);
    endtask

    initial
    begin
        logic [8:0] directed [DIRECTED_N];
        int         i;
        int         line_no;
        int         ending_kind;

        // empty line, backspace, backspace on empty store, dropped codes,
        // high bytes with trailing blanks, tab stop, flush by end of input,
        // end of input with nothing open, end of input after a dropped code only
        directed = '{
            {1'b0, tlc_pkg::CH_NL},
            {1'b0, "a"}, {1'b0, "b"}, {1'b0, tlc_pkg::CH_BS}, {1'b0, tlc_pkg::CH_NL},
            {1'b0, tlc_pkg::CH_BS}, {1'b0, tlc_pkg::CH_NL},
            9'h000, {1'b0, tlc_pkg::CH_DEL}, {1'b0, tlc_pkg::CH_NL},
            9'h0ff, 9'h080, {1'b0, tlc_pkg::CH_SP}, {1'b0, tlc_pkg::CH_TAB},
            {1'b0, tlc_pkg::CH_NL},
            {1'b0, tlc_pkg::CH_TAB}, {1'b0, "x"}, {1'b0, tlc_pkg::CH_SP}, {1'b0, "y"},
            {1'b0, tlc_pkg::CH_NL},
            {1'b0, "q"}, END_MARK,
            END_MARK,
            9'h007, END_MARK
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_N; i++) begin
            if (directed[i][8])
                send_item(8'($urandom_range(0, 255)), 1'b1);
            else
                send_item(directed[i][7:0], 1'b0);
        end

        // mostly whole lines with random content; the first fills the store and
        // backspaces into the discard, the second tries to overflow through tab expansion
        line_no = 0;
        while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
            if (line_no == 0) begin
                send_line(66, PRINTABLE);
                send_item(tlc_pkg::CH_BS, 1'b0);
            end
            else if (line_no == 1)
                send_line(16, TAB_HEAVY);
            else if ($urandom_range(0, 9) == 0)
                send_line($urandom_range(55, 80), MIXED);
            else
                send_line($urandom_range(0, 20),
                          ($urandom_range(0, 3) == 0) ? TAB_HEAVY : MIXED);

            ending_kind = $urandom_range(0, 19);
            if (ending_kind < 16)
                send_item(tlc_pkg::CH_NL, 1'b0);
            else
                send_item(8'($urandom_range(0, 255)), 1'b1);
            // a second end of input finds nothing open
            if (ending_kind == 19)
                send_item(8'($urandom_range(0, 255)), 1'b1);
            // raw noise that runs into the next line
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 4)) send_item(8'($urandom_range(0, 255)), 1'b0);
            line_no++;
        end
        s_tvalid <= 1'b0;
        // let the monitor note the last accepted item first
        @(posedge clk);

        while (chk.canon_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (chk.canon_q.size() != 0)
            $error("%0d expected characters never arrived", chk.canon_q.size());
        if (chk.errors == 0 && chk.canon_q.size() == 0)
            $display("tb_text_line_canonicalizer OK");
        else
            $display("tb_text_line_canonicalizer NOT OK");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("tb_text_line_canonicalizer NOT OK");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/tlc_pkg.sv
rtl/tlc_ctrl.sv
rtl/tlc_datapath.sv
rtl/text_line_canonicalizer.sv
sim/tb_text_line_canonicalizer.sv
